// ----- sv/wpt_pkg.sv -----
package wpt_pkg;

	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int VAL_W = 32;
	localparam int PCT_W = 7;
	localparam int PROD_W = PCT_W + CNT_W;

	localparam logic [PCT_W-1:0] PCT_MIN = 7'd10;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd90;
	localparam logic [PCT_W-1:0] PCT_RESET = 7'd80;
	localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	// Division by 100 is a multiply by the reciprocal of 100, scaled by 2^32 and rounded up.
	localparam int RECIP_SH = 32;
	localparam longint RECIP_L = (64'd1 << RECIP_SH) / 100 + 1;
	localparam int RECIP_W = 26;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_L[RECIP_W-1:0];
	localparam int Q_W = PROD_W + RECIP_W - RECIP_SH;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_MISSING = 2'd2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_PCT = 3'd0;

	typedef struct packed {
		logic ins;
		logic rem;
		logic signed [VAL_W-1:0] value;
	} cell_op_t;

	typedef struct packed {
		logic ready;
		logic exact;
		logic [CNT_W-1:0] rank;
	} rank_info_t;

endpackage

// ----- sv/wpt_cell.sv -----
module wpt_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wpt_pkg::cell_op_t                   op,
	input  logic signed [wpt_pkg::VAL_W-1:0]    left_val,
	input  logic                                left_vld,
	input  logic                                left_gt,
	input  logic signed [wpt_pkg::VAL_W-1:0]    right_val,
	input  logic                                right_vld,
	output logic signed [wpt_pkg::VAL_W-1:0]    val,
	output logic                                vld,
	output logic                                gt,
	output logic                                eq
);

	logic signed [wpt_pkg::VAL_W-1:0] val_q;
	logic                             vld_q;
	logic                             ge;

	// An empty cell counts as greater so that the insert point falls on it.
	assign gt  = !vld_q || (val_q > op.value);
	assign ge  = vld_q && (val_q >= op.value);
	assign eq  = vld_q && (val_q == op.value);
	assign val = val_q;
	assign vld = vld_q;

	always_ff @(posedge clk) begin
		if (op.ins && gt) begin
			val_q <= left_gt ? left_val : op.value;
		end else if (op.rem && ge) begin
			val_q <= right_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (op.ins && gt) begin
			vld_q <= left_gt ? left_vld : 1'b1;
		end else if (op.rem && ge) begin
			vld_q <= right_vld;
		end
	end

endmodule

// ----- sv/wpt_rank.sv -----
module wpt_rank (
	input  logic                           clk,
	input  logic [wpt_pkg::PCT_W-1:0]      pct,
	input  logic [wpt_pkg::CNT_W-1:0]      count,
	output wpt_pkg::rank_info_t            info
);

	localparam int PROD_W = wpt_pkg::PROD_W;
	localparam int Q_W = wpt_pkg::Q_W;
	localparam int MUL_W = PROD_W + wpt_pkg::RECIP_W;

	logic [wpt_pkg::PCT_W-1:0] lo_w;
	logic [wpt_pkg::PCT_W-1:0] hi_w;
	logic [PROD_W-1:0]         cross_w;
	logic [PROD_W-1:0]         prod_s1;
	logic [wpt_pkg::CNT_W-1:0] count_s1;
	logic                      ready_s1;
	logic [MUL_W-1:0]          qm_w;
	logic [Q_W-1:0]            q0_w;
	logic [Q_W+6:0]            q100_w;
	logic                      rem0_w;
	logic [Q_W:0]              rank_w;
	wpt_pkg::rank_info_t       info_s2;

	// Ready when count > floor(b / a), checked as count * a > b.
	always_comb begin
		if (pct <= wpt_pkg::PCT_HALF) begin
			lo_w = pct;
			hi_w = wpt_pkg::PCT_FULL - pct;
		end else begin
			lo_w = wpt_pkg::PCT_FULL - pct;
			hi_w = pct;
		end
		cross_w = PROD_W'(count) * PROD_W'(lo_w);
	end

	always_ff @(posedge clk) begin
		prod_s1  <= PROD_W'(pct) * PROD_W'(count);
		count_s1 <= count;
		ready_s1 <= cross_w > PROD_W'(hi_w);
	end

	always_comb begin
		qm_w   = MUL_W'(prod_s1) * MUL_W'(wpt_pkg::RECIP_C);
		q0_w   = qm_w[MUL_W-1:wpt_pkg::RECIP_SH];
		q100_w = ((Q_W+7)'(q0_w) << 6) + ((Q_W+7)'(q0_w) << 5) + ((Q_W+7)'(q0_w) << 2);
		rem0_w = (q100_w == (Q_W+7)'(prod_s1));
		rank_w = rem0_w ? (Q_W+1)'(q0_w) : (Q_W+1)'(q0_w) + 1'b1;
		if (rank_w == '0) begin
			rank_w = (Q_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		info_s2.ready <= ready_s1;
		info_s2.exact <= ready_s1 && rem0_w && ((Q_W+1)'(count_s1) > rank_w);
		info_s2.rank  <= rank_w[wpt_pkg::CNT_W-1:0];
	end

	assign info = info_s2;

endmodule

// ----- sv/window_percentile_tracker.sv -----
// Sorted chain of 64 cells; an insert or remove shifts the chain by one in the accept cycle.
// An item passes the states RANK, SEL and OUT before its result is offered; OUT waits while
// an unread result blocks the output. The states cover the rank stages (multiply, divide
// by 100, then the rank select across the chain); a new item is taken while a result waits.
// Reset: empty store, percentile 80, no result pending.
module window_percentile_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // [31:0] value
	input  logic [0:0]                        s_tuser,  // [0] kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] status, [2] ready_res, [9:3] item_count, [41:10] rank_value,
	// [42] exact_split, [74:43] next_value, [79:75] zero
	output logic [79:0]                       m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wpt_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int DEPTH = wpt_pkg::DEPTH;
	localparam int CNT_W = wpt_pkg::CNT_W;
	localparam int IDX_W = wpt_pkg::IDX_W;
	localparam int VAL_W = wpt_pkg::VAL_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RANK = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                      state_q;
	logic [wpt_pkg::PCT_W-1:0]       pct_q;
	logic [CNT_W-1:0]                count_q;
	logic [1:0]                      status_q;
	logic                            m_tvalid_q;
	logic [79:0]                     m_tdata_q;

	logic                            accept;
	logic                            cfg_wr;
	logic [wpt_pkg::PCT_W-1:0]       wdata7;
	logic                            full;
	logic                            found;
	logic                            out_free;
	wpt_pkg::cell_op_t               op;
	wpt_pkg::rank_info_t             info;

	logic signed [VAL_W-1:0]         val_w [DEPTH];
	logic [DEPTH-1:0]                vld_w;
	logic [DEPTH-1:0]                gt_w;
	logic [DEPTH-1:0]                eq_w;
	logic signed [VAL_W-1:0]         rank_val;
	logic signed [VAL_W-1:0]         next_val;
	logic [IDX_W-1:0]                rank_idx;
	logic [IDX_W-1:0]                next_idx;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign found    = |eq_w;
	assign out_free = !m_tvalid_q || m_tready;

	assign op.value = s_tdata;
	assign op.ins   = accept && (s_tuser[0] == wpt_pkg::KIND_INSERT) && !full;
	assign op.rem   = accept && (s_tuser[0] == wpt_pkg::KIND_REMOVE) && found;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] lv;
		logic                    lvld;
		logic                    lgt;
		logic signed [VAL_W-1:0] rv;
		logic                    rvld;

		if (i == 0) begin : g_first
			assign lv   = '0;
			assign lvld = 1'b0;
			assign lgt  = 1'b0;
		end else begin : g_mid_l
			assign lv   = val_w[i-1];
			assign lvld = vld_w[i-1];
			assign lgt  = gt_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_mid_r
			assign rv   = val_w[i+1];
			assign rvld = vld_w[i+1];
		end

		wpt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.left_val  (lv),
			.left_vld  (lvld),
			.left_gt   (lgt),
			.right_val (rv),
			.right_vld (rvld),
			.val       (val_w[i]),
			.vld       (vld_w[i]),
			.gt        (gt_w[i]),
			.eq        (eq_w[i])
		);
	end

	wpt_rank u_rank (
		.clk   (clk),
		.pct   (pct_q),
		.count (count_q),
		.info  (info)
	);

	// The rank is 1-based, so rank-1 picks the element and rank picks its successor.
	assign rank_idx = IDX_W'(info.rank - 1'b1);
	assign next_idx = info.rank[IDX_W-1:0];

	always_comb begin
		rank_val = '0;
		next_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (IDX_W'(i) == rank_idx) begin
				rank_val = val_w[i];
			end
			if (IDX_W'(i) == next_idx) begin
				next_val = val_w[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (op.ins) begin
				count_q <= count_q + 1'b1;
			end else if (op.rem) begin
				count_q <= count_q - 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RANK;
					end
				end
				ST_RANK: state_q <= ST_SEL;
				ST_SEL:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (s_tuser[0] == wpt_pkg::KIND_INSERT) begin
				status_q <= full ? wpt_pkg::STAT_FULL : wpt_pkg::STAT_OK;
			end else begin
				status_q <= found ? wpt_pkg::STAT_OK : wpt_pkg::STAT_MISSING;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q[1:0]   <= status_q;
			m_tdata_q[2]     <= info.ready;
			m_tdata_q[9:3]   <= 7'(count_q);
			m_tdata_q[41:10] <= info.ready ? rank_val : '0;
			m_tdata_q[42]    <= info.exact;
			m_tdata_q[74:43] <= info.exact ? next_val : '0;
			m_tdata_q[79:75] <= '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Configuration port: writes land in the access phase and are clamped to 10..90.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == wpt_pkg::ADDR_PCT);
	assign wdata7 = pwdata[wpt_pkg::PCT_W-1:0];
	assign prdata = (paddr == wpt_pkg::ADDR_PCT) ? {25'd0, pct_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= wpt_pkg::PCT_RESET;
		end else if (cfg_wr) begin
			if (wdata7 < wpt_pkg::PCT_MIN) begin
				pct_q <= wpt_pkg::PCT_MIN;
			end else if (wdata7 > wpt_pkg::PCT_MAX) begin
				pct_q <= wpt_pkg::PCT_MAX;
			end else begin
				pct_q <= wdata7;
			end
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS = 100;
	// Byte address of register index 1, which does not exist.
	localparam logic [wpt_pkg::ADDR_W-1:0] ADDR_SPARE = 3'd4;

	typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} mix_t;

	typedef struct packed {
		logic kind;
		logic [31:0] value;
	} window_op_t;

	typedef struct packed {
		logic [1:0] status;
		logic ready;
		logic [6:0] count;
		logic [31:0] rank_v;
		logic exact;
		logic [31:0] next_v;
	} window_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] value
	logic [0:0] s_tuser = '0;    // [0] kind
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [1:0] status, [2] ready_res, [9:3] item_count, [41:10] rank_value,
	// [42] exact_split, [74:43] next_value, [79:75] zero
	logic [79:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [wpt_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	window_percentile_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// Sorted window as the block should hold it, updated at each accepted input beat.
	logic signed [31:0] held [wpt_pkg::DEPTH];
	int held_n = 0;
	logic [6:0] pct_now = wpt_pkg::PCT_RESET;

	window_result_t pending_results[$];
	window_op_t op_backlog[$];
	logic [31:0] gen_held[$];

	int fail_count = 0;
	int result_idx = 0;
	int idle_cycles = 0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	logic send_idle = 1'b1;
	logic recv_idle = 1'b1;
	int send_wait = 0;
	int recv_wait = 0;
	int hold_orders = 0;
	int hold_served = 0;
	int hold_left = 0;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic window_result_t apply_window_op(logic kind, logic signed [31:0] v);
		window_result_t r;
		int pos;
		int j;
		int p;
		int need;
		int prod;
		int rank;
		r = '0;
		p = pct_now;
		pos = 0;
		if (kind == wpt_pkg::KIND_REMOVE) begin
			while (pos < held_n && held[pos] != v)
				pos++;
			if (pos == held_n) begin
				r.status = wpt_pkg::STAT_MISSING;
			end else begin
				for (j = pos; j < held_n - 1; j++)
					held[j] = held[j + 1];
				held_n--;
			end
		end else if (held_n >= wpt_pkg::DEPTH) begin
			r.status = wpt_pkg::STAT_FULL;
		end else begin
			// Equal values already held stay ahead of the new one.
			while (pos < held_n && held[pos] <= v)
				pos++;
			for (j = held_n; j > pos; j--)
				held[j] = held[j - 1];
			held[pos] = v;
			held_n++;
		end

		if (p < wpt_pkg::PCT_HALF)
			need = (wpt_pkg::PCT_FULL - p) / p + 1;
		else if (p > wpt_pkg::PCT_HALF)
			need = p / (wpt_pkg::PCT_FULL - p) + 1;
		else
			need = 2;
		r.count = held_n[6:0];
		if (held_n >= need && held_n > 0) begin
			prod = p * held_n;
			rank = (prod + wpt_pkg::PCT_FULL - 1) / wpt_pkg::PCT_FULL;
			if (rank < 1)
				rank = 1;
			if (rank > held_n)
				rank = held_n;
			r.ready = 1'b1;
			r.rank_v = held[rank - 1];
			if (prod % wpt_pkg::PCT_FULL == 0 && rank < held_n) begin
				r.exact = 1'b1;
				r.next_v = held[rank];
			end
		end
		return r;
	endfunction

	// Queues one operation and keeps the generator's own view of the window in step.
	function automatic void queue_op(logic kind, logic [31:0] v);
		window_op_t op;
		int k;
		op.kind = kind;
		op.value = v;
		op_backlog.push_back(op);
		if (kind == wpt_pkg::KIND_INSERT) begin
			if (gen_held.size() < wpt_pkg::DEPTH)
				gen_held.push_back(v);
		end else begin
			for (k = 0; k < gen_held.size(); k++) begin
				if (gen_held[k] == v) begin
					gen_held.delete(k);
					break;
				end
			end
		end
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] corner_vals [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 16) - 32'd8;
			2: return corner_vals[$urandom_range(0, 3)];
			default: return $urandom_range(0, 2000) - 32'd1000;
		endcase
	endfunction

	task automatic apb_access(input logic wr, input logic [wpt_pkg::ADDR_W-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_percentile_reg();
		logic [31:0] rd;
		apb_access(1'b0, wpt_pkg::ADDR_PCT, '0, rd);
		if (rd !== {25'd0, pct_now})
			report_mismatch($sformatf("percentile readback %0d, want %0d", rd, pct_now));
	endtask

	task automatic set_percentile(input logic [31:0] raw);
		logic [31:0] rd;
		logic [6:0] want;
		want = raw[6:0];
		if (want < wpt_pkg::PCT_MIN)
			want = wpt_pkg::PCT_MIN;
		else if (want > wpt_pkg::PCT_MAX)
			want = wpt_pkg::PCT_MAX;
		apb_access(1'b1, wpt_pkg::ADDR_PCT, raw, rd);
		pct_now = want;
		check_percentile_reg();
	endtask

	task automatic wait_drained();
		while (op_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input int seq, input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%08h, want 0x%08h",
				seq, name, got, want));
	endtask

	// Input side: the next beat goes out once the previous one was taken.
	always @(negedge clk) begin
		window_op_t op;
		if (in_taken)
			send_wait = send_idle ? $urandom_range(0, 9) : 0;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (send_wait > 0) begin
				send_wait--;
				s_tvalid <= 1'b0;
			end else if (op_backlog.size() > 0) begin
				op = op_backlog.pop_front();
				s_tuser <= op.kind;
				s_tdata <= op.value;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output side: a random wait after each beat when recv_idle is set, plus a long hold-off when ordered.
	always @(negedge clk) begin
		if (out_taken)
			recv_wait = recv_idle ? $urandom_range(0, 9) : 0;
		if (hold_served != hold_orders) begin
			hold_served = hold_orders;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (recv_wait > 0) begin
			recv_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		window_result_t want;
		in_taken <= s_tvalid && s_tready;
		out_taken <= m_tvalid && m_tready;
		if (s_tvalid && s_tready)
			pending_results.push_back(apply_window_op(s_tuser[0], s_tdata));
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat 0x%020h with nothing pending", m_tdata));
			end else begin
				want = pending_results.pop_front();
				check_field(result_idx, "status", 32'(m_tdata[1:0]), 32'(want.status));
				check_field(result_idx, "ready_res", 32'(m_tdata[2]), 32'(want.ready));
				check_field(result_idx, "item_count", 32'(m_tdata[9:3]), 32'(want.count));
				check_field(result_idx, "rank_value", m_tdata[41:10], want.rank_v);
				check_field(result_idx, "exact_split", 32'(m_tdata[42]), 32'(want.exact));
				check_field(result_idx, "next_value", m_tdata[74:43], want.next_v);
				check_field(result_idx, "pad", 32'(m_tdata[79:75]), '0);
			end
			result_idx++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("window_percentile_tracker verification failed");
			$finish;
		end
	end

	initial begin
		int pct_plan [13] = '{10, 90, 50, 0, 127, 33, 67, 75, 25, 11, 89, 49, 51};
		logic [31:0] raw;
		logic [31:0] rd;
		mix_t mix;
		int insert_pct;
		int ph;
		int i;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_percentile_reg();

		// Directed part at the reset percentile of 80, which needs five values.
		queue_op(wpt_pkg::KIND_REMOVE, 32'd0);
		queue_op(wpt_pkg::KIND_INSERT, 32'h8000_0000);
		queue_op(wpt_pkg::KIND_INSERT, 32'h7FFF_FFFF);
		queue_op(wpt_pkg::KIND_INSERT, 32'd0);
		queue_op(wpt_pkg::KIND_INSERT, 32'hFFFF_FFFF);
		queue_op(wpt_pkg::KIND_INSERT, 32'd5);
		queue_op(wpt_pkg::KIND_INSERT, 32'd5);
		queue_op(wpt_pkg::KIND_INSERT, 32'd5);
		queue_op(wpt_pkg::KIND_REMOVE, 32'd5);
		queue_op(wpt_pkg::KIND_REMOVE, 32'd7);
		queue_op(wpt_pkg::KIND_INSERT, 32'd1);
		queue_op(wpt_pkg::KIND_REMOVE, 32'h8000_0000);
		queue_op(wpt_pkg::KIND_REMOVE, 32'h7FFF_FFFF);
		queue_op(wpt_pkg::KIND_INSERT, 32'h7FFF_FFFF);
		queue_op(wpt_pkg::KIND_INSERT, 32'h8000_0000);
		queue_op(wpt_pkg::KIND_INSERT, 32'hAAAA_AAAA);
		queue_op(wpt_pkg::KIND_INSERT, 32'h5555_5555);
		queue_op(wpt_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
		queue_op(wpt_pkg::KIND_REMOVE, 32'h8000_0000);
		queue_op(wpt_pkg::KIND_REMOVE, 32'hAAAA_AAAA);
		wait_drained();

		// A write to an address past the register list must leave the percentile alone.
		apb_access(1'b1, ADDR_SPARE, 32'd20, rd);
		check_percentile_reg();

		for (ph = 0; ph < 13; ph++) begin
			raw = pct_plan[ph];
			if (ph % 2 == 1)
				raw = raw | ($urandom & 32'hFFFF_FF80);
			set_percentile(raw);
			send_idle = (ph % 4) != 1;
			recv_idle = (ph % 4) != 2;
			mix = mix_t'(ph % 3);
			insert_pct = (mix == MIX_GROW) ? 85 : (mix == MIX_CHURN) ? 50 : 15;
			// The receiver stops while the sender streams without gaps, so the block backs up.
			if (ph == 1)
				hold_orders++;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(1, 100) <= insert_pct)
					queue_op(wpt_pkg::KIND_INSERT, pick_value());
				else if (gen_held.size() > 0 && $urandom_range(0, 9) < 8)
					queue_op(wpt_pkg::KIND_REMOVE,
						gen_held[$urandom_range(0, gen_held.size() - 1)]);
				else
					queue_op(wpt_pkg::KIND_REMOVE, pick_value());
			end
			wait_drained();
		end

		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("window_percentile_tracker verification clean");
		else
			$display("window_percentile_tracker verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/wpt_pkg.sv
sv/wpt_cell.sv
sv/wpt_rank.sv
sv/window_percentile_tracker.sv
verif/testbench.sv
